### rtl/sfb_pkg.sv
// shared types, constants and breakpoint table for the sigmoid forward/backward unit
package sfb_pkg;

  localparam int VAL_W    = 17;  // operand_value / result_value width
  localparam int GRAD_W   = 16;  // upstream_grad width (Q4.12)
  localparam int SEG_BITS = 5;   // log2 of the segment count
  localparam int SEG_CNT  = 1 << SEG_BITS;
  localparam int X_BITS   = 15;  // |x| below 8.0 in Q4.12
  localparam int FRAC_W   = 15;  // interpolation fraction width
  localparam int LOC_W    = 31;  // y*(1-y) in Q0.32, at most 2^30
  localparam int OPA_W    = 16;
  localparam int OPB_W    = 31;
  localparam int PROD_W   = OPA_W + OPB_W;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  localparam logic [15:0] Y_MAX    = 16'hFFFF;
  localparam logic [GRAD_W-1:0] G_POS_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0] G_NEG_MAX = {1'b1, {(GRAD_W-1){1'b0}}};

  // round(65536*sigmoid(k/4)), clipped to 65535
  localparam logic [15:0] BP_TABLE [0:SEG_CNT] = '{
    16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941, 16'd53581,
    16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598, 16'd62428, 16'd63090,
    16'd63615, 16'd64030, 16'd64357, 16'd64614, 16'd64816, 16'd64974, 16'd65097,
    16'd65194, 16'd65269, 16'd65328, 16'd65374, 16'd65410, 16'd65438, 16'd65459,
    16'd65476, 16'd65489, 16'd65500, 16'd65508, 16'd65514
  };

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] operand_value;
    logic signed [GRAD_W-1:0] upstream_grad;
  } in_t;

  typedef struct packed {
    logic             mode;
    logic             sat;   // forward |x| >= 8
    logic             neg;   // x < 0 in forward, t < 0 in backward
    logic [15:0]      lo;
    logic [OPA_W-1:0] opa;   // segment slope or |t|
    logic [OPB_W-1:0] opb;   // fraction or y*(1-y)
  } s1_t;

  typedef struct packed {
    logic              mode;
    logic              sat;
    logic              neg;
    logic [15:0]       lo;
    logic [PROD_W-1:0] prod;
  } s2_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    result_mode;
  } out_t;

endpackage

### rtl/sfb_if.sv
// valid/ready stream interfaces for requests and results
interface sfb_in_if (input logic clk);
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [sfb_pkg::VAL_W-1:0]    operand_value;
  logic signed [sfb_pkg::GRAD_W-1:0]   upstream_grad;

  modport source (input clk, output valid, output cmd, output operand_value,
                  output upstream_grad, input ready);
  modport sink (input clk, input valid, input cmd, input operand_value,
                input upstream_grad, output ready);
endinterface

interface sfb_out_if (input logic clk);
  logic                             valid;
  logic                             ready;
  logic signed [sfb_pkg::VAL_W-1:0] result_value;
  logic                             result_mode;

  modport source (input clk, output valid, output result_value, output result_mode,
                  input ready);
  modport sink (input clk, input valid, input result_value, input result_mode,
                output ready);
endinterface

### rtl/sigmoid_forward_backward_unit.sv
// top level: three-stage sigmoid forward/backward pipeline
//
//   channel  dir  payload
//   req      in   cmd, operand_value, upstream_grad
//   rsp      out  result_value, result_mode
//
// one transaction per cycle unless rsp stalls; every stage registers its result.
// stages: table lookup and y*(1-y) product, one shared 16x31 multiplier, round/saturate.
// each stage holds its own valid bit and moves when it is empty or the next one moves,
// so bubbles close up and a stalled rsp never drops or repeats a transaction.
// synchronous reset clears the valid bits only.
module sigmoid_forward_backward_unit (
  input  logic       clk,
  input  logic       rst,
  sfb_in_if.sink     req,
  sfb_out_if.source  rsp
);
  import sfb_pkg::*;

  in_t  req_data;
  s1_t  s1_data;
  s2_t  s2_data;
  out_t rsp_data;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;
  logic s3_ready;

  assign req_data.cmd           = req.cmd;
  assign req_data.operand_value = req.operand_value;
  assign req_data.upstream_grad = req.upstream_grad;

  sfb_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .valid_i (req.valid),
    .data_i  (req_data),
    .ready_o (req.ready),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  sfb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  sfb_finish u_finish (
    .clk     (clk),
    .rst     (rst),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s2_ready),
    .valid_o (rsp.valid),
    .data_o  (rsp_data),
    .ready_i (s3_ready)
  );

  assign s3_ready         = rsp.ready;
  assign rsp.result_value = rsp_data.result_value;
  assign rsp.result_mode  = rsp_data.result_mode;

endmodule

### rtl/sfb_prep.sv
// stage 1: segment lookup for forward, y*(1-y) product for backward
module sfb_prep (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_i,
  input  sfb_pkg::in_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output sfb_pkg::s1_t data_o,
  input  logic         ready_i
);
  import sfb_pkg::*;

  logic             x_neg;
  logic [VAL_W-1:0] x_abs;
  logic [SEG_BITS-1:0] idx;
  logic [SEG_BITS:0]   idx_hi;
  logic [15:0]      lo;
  logic [15:0]      hi;
  logic [15:0]      yu;
  logic [16:0]      y_comp;
  logic [32:0]      local_full;
  logic             t_neg;
  logic [GRAD_W-1:0] t_abs;
  s1_t              s1_next;
  logic             vld;

  always_comb begin
    x_neg  = data_i.operand_value[VAL_W-1];
    x_abs  = x_neg ? VAL_W'(-data_i.operand_value) : VAL_W'(data_i.operand_value);
    idx    = x_abs[X_BITS-1:X_BITS-SEG_BITS];
    idx_hi = {1'b0, idx} + (SEG_BITS+1)'(1);
    lo     = BP_TABLE[idx];
    hi     = BP_TABLE[idx_hi];

    // negative y reads as zero
    yu         = x_neg ? 16'd0 : data_i.operand_value[15:0];
    y_comp     = 17'h10000 - {1'b0, yu};
    local_full = {17'd0, yu} * {16'd0, y_comp};
    t_neg      = data_i.upstream_grad[GRAD_W-1];
    t_abs      = t_neg ? GRAD_W'(-data_i.upstream_grad) : GRAD_W'(data_i.upstream_grad);

    s1_next.mode = data_i.cmd;
    s1_next.lo   = lo;
    if (data_i.cmd == MODE_FWD) begin
      s1_next.sat = x_abs[VAL_W-1] | x_abs[X_BITS];
      s1_next.neg = x_neg;
      s1_next.opa = OPA_W'(hi - lo);
      s1_next.opb = OPB_W'({x_abs[X_BITS-SEG_BITS-1:0], {SEG_BITS{1'b0}}});
    end else begin
      s1_next.sat = 1'b0;
      s1_next.neg = t_neg;
      s1_next.opa = OPA_W'(t_abs);
      s1_next.opb = local_full[LOC_W-1:0];
    end
  end

  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= s1_next;
    end
  end

endmodule

### rtl/sfb_mul.sv
// stage 2: shared multiplier, slope*fraction or |t|*y*(1-y)
module sfb_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_i,
  input  sfb_pkg::s1_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output sfb_pkg::s2_t data_o,
  input  logic         ready_i
);
  import sfb_pkg::*;

  s2_t  s2_next;
  logic vld;

  always_comb begin
    s2_next.mode = data_i.mode;
    s2_next.sat  = data_i.sat;
    s2_next.neg  = data_i.neg;
    s2_next.lo   = data_i.lo;
    s2_next.prod = {{OPB_W{1'b0}}, data_i.opa} * {{OPA_W{1'b0}}, data_i.opb};
  end

  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= s2_next;
    end
  end

endmodule

### rtl/sfb_finish.sv
// stage 3: rounding, mirroring and saturation into the output register
module sfb_finish (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_i,
  input  sfb_pkg::s2_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output sfb_pkg::out_t data_o,
  input  logic         ready_i
);
  import sfb_pkg::*;

  logic [31:0]       f_sum;
  logic [17:0]       yp;
  logic [15:0]       yp_sat;
  logic [VAL_W-1:0]  fwd_val;
  logic [PROD_W:0]   b_sum;
  logic [GRAD_W:0]   r;
  logic [GRAD_W:0]   r_sat;
  logic [VAL_W-1:0]  bwd_val;
  out_t              out_next;
  logic              vld;

  always_comb begin
    // interpolation remainder rounded half up
    f_sum  = data_i.prod[31:0] + 32'd16384;
    yp     = {2'b00, data_i.lo} + {1'b0, f_sum[31:15]};
    yp_sat = (yp > {2'b00, Y_MAX}) ? Y_MAX : yp[15:0];
    if (data_i.sat) begin
      fwd_val = data_i.neg ? VAL_W'(0) : {1'b0, Y_MAX};
    end else if (data_i.neg) begin
      fwd_val = 17'h10000 - {1'b0, yp_sat};
    end else begin
      fwd_val = {1'b0, yp_sat};
    end

    // Q4.44 to Q4.12, magnitude rounded half up, i.e. half away from zero
    b_sum = {1'b0, data_i.prod} + (PROD_W+1)'(64'h8000_0000);
    r     = {1'b0, b_sum[GRAD_W+31:32]};
    if (data_i.neg) begin
      r_sat   = (r > {1'b0, G_NEG_MAX}) ? {1'b0, G_NEG_MAX} : r;
      bwd_val = VAL_W'(0) - VAL_W'(r_sat);
    end else begin
      r_sat   = (r > {1'b0, G_POS_MAX}) ? {1'b0, G_POS_MAX} : r;
      bwd_val = VAL_W'(r_sat);
    end

    out_next.result_mode  = data_i.mode;
    out_next.result_value = (data_i.mode == MODE_FWD) ? fwd_val : bwd_val;
  end

  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= out_next;
    end
  end

endmodule
